[rtl/x86pw_pkg.sv]
package x86pw_pkg;

    // item modes as they arrive on the input channel
    typedef enum logic [1:0] {
        MODE_STORE     = 2'd0,
        MODE_TRANSLATE = 2'd1,
        MODE_FAULT     = 2'd2,
        MODE_UNUSED    = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_PAGING_OFF  = 3'd0,
        ST_DIR_ABSENT  = 3'd1,
        ST_TBL_ABSENT  = 3'd2,
        ST_MAPPED_4M   = 3'd3,
        ST_MAPPED_4K   = 3'd4,
        ST_ERROR_CODE  = 3'd5
    } status_t;

    // work classes handed from front to back
    typedef enum logic [1:0] {
        OP_STORE     = 2'd0,
        OP_DIRECT    = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_FAULT     = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic CFG_PAGING_ENABLE = 1'b0;
    localparam logic CFG_DIR_BASE      = 1'b1;

    // entry bit positions
    localparam int ENT_PRESENT_BIT = 0;
    localparam int ENT_RW_BIT      = 1;
    localparam int ENT_BIG_BIT     = 7;

    // error code bit positions
    localparam int EC_PRESENT_BIT = 0;
    localparam int EC_WRITE_BIT   = 1;
    localparam int EC_USER_BIT    = 2;
    localparam int EC_FETCH_BIT   = 4;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        op_t         op;
        logic [31:0] address;
        logic [31:0] data;
        status_t     status;
        logic [4:0]  code;
    } cmd_t;

endpackage

[rtl/x86pw_front.sv]
module x86pw_front (
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         mode,
    input  logic [31:0]        address,
    input  logic [31:0]        data,
    input  logic               access_rejected,
    input  logic               fetch_at_address,
    input  logic               user_mode,
    input  logic               paging_enable,
    input  logic               q_full,
    output logic               q_push,
    output x86pw_pkg::cmd_t    q_cmd
);
    import x86pw_pkg::*;

    logic keep;
    logic [4:0] base_code;

    // error code without the write bit, which only a walk can settle
    always_comb
    begin
        base_code                 = '0;
        base_code[EC_FETCH_BIT]   = fetch_at_address;
        base_code[EC_USER_BIT]    = user_mode;
        base_code[EC_PRESENT_BIT] = access_rejected;
    end

    always_comb
    begin
        keep           = 1'b1;
        q_cmd.op       = OP_DIRECT;
        q_cmd.address  = address;
        q_cmd.data     = data;
        q_cmd.status   = ST_PAGING_OFF;
        q_cmd.code     = '0;
        unique case (mode_t'(mode))
            MODE_STORE:
            begin
                q_cmd.op = OP_STORE;
            end
            MODE_TRANSLATE:
            begin
                q_cmd.op = paging_enable ? OP_TRANSLATE : OP_DIRECT;
            end
            MODE_FAULT:
            begin
                q_cmd.op     = (access_rejected && !fetch_at_address) ? OP_FAULT : OP_DIRECT;
                q_cmd.status = ST_ERROR_CODE;
                q_cmd.code   = base_code;
            end
            MODE_UNUSED:
            begin
                keep = 1'b0;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign item_ready = !q_full;
    assign q_push     = item_valid && item_ready && keep;

endmodule

[rtl/x86pw_queue.sv]
module x86pw_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  x86pw_pkg::cmd_t    push_cmd,
    output logic               full,
    output logic               valid,
    output x86pw_pkg::cmd_t    head_cmd,
    input  logic               pop
);
    import x86pw_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // depth is a power of two, pointers wrap on their own
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

[rtl/x86pw_back.sv]
module x86pw_back #(
    parameter int MEM_WORDS = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          dir_base,
    input  logic                 q_valid,
    input  x86pw_pkg::cmd_t      q_cmd,
    output logic                 q_pop,
    output logic                 result_valid,
    input  logic                 result_ready,
    output x86pw_pkg::status_t   status,
    output logic [31:0]          frame_base,
    output logic                 writable,
    output logic [4:0]           error_code
);
    import x86pw_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIR,
        S_TBL
    } state_t;

    state_t      state_reg, state_next;
    cmd_t        cur_reg, cur_next;
    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;
    logic [31:0] frame_reg, frame_next;
    logic        wr_reg, wr_next;
    logic [4:0]  code_reg, code_next;

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rdata_reg;
    logic        mem_we;
    logic        mem_re;
    logic [AW-1:0] mem_addr;
    logic        out_free;
    logic        load;
    logic [29:0] dir_word;
    logic [29:0] tbl_word;
    logic [31:0] ent;

    assign ent      = rdata_reg;
    assign out_free = !out_valid_reg || result_ready;
    // 4 KiB aligned base plus a ten bit index, as a word number
    assign dir_word = {dir_base[31:12], q_cmd.address[31:22]};
    assign tbl_word = {ent[31:12], cur_reg.address[21:12]};

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = q_cmd.address[AW+1:2];
        load        = 1'b0;
        status_next = status_reg;
        frame_next  = frame_reg;
        wr_next     = wr_reg;
        code_next   = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_STORE:
                        begin
                            q_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        OP_DIRECT:
                        begin
                            if (out_free)
                            begin
                                q_pop       = 1'b1;
                                load        = 1'b1;
                                status_next = q_cmd.status;
                                frame_next  = '0;
                                wr_next     = 1'b0;
                                code_next   = q_cmd.code;
                            end
                        end
                        OP_TRANSLATE, OP_FAULT:
                        begin
                            q_pop      = 1'b1;
                            mem_re     = 1'b1;
                            mem_addr   = dir_word[AW-1:0];
                            cur_next   = q_cmd;
                            state_next = S_DIR;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_DIR:
            begin
                if (cur_reg.op == OP_TRANSLATE && !ent[ENT_PRESENT_BIT])
                begin
                    if (out_free)
                    begin
                        load        = 1'b1;
                        status_next = ST_DIR_ABSENT;
                        frame_next  = '0;
                        wr_next     = 1'b0;
                        code_next   = '0;
                        state_next  = S_IDLE;
                    end
                end
                else if (ent[ENT_BIG_BIT])
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        state_next = S_IDLE;
                        if (cur_reg.op == OP_TRANSLATE)
                        begin
                            status_next = ST_MAPPED_4M;
                            frame_next  = {ent[31:22], 22'd0};
                            wr_next     = ent[ENT_RW_BIT];
                            code_next   = '0;
                        end
                        else
                        begin
                            status_next = ST_ERROR_CODE;
                            frame_next  = '0;
                            wr_next     = 1'b0;
                            code_next   = cur_reg.code;
                            code_next[EC_WRITE_BIT] = !ent[ENT_RW_BIT];
                        end
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = tbl_word[AW-1:0];
                    state_next = S_TBL;
                end
            end
            S_TBL:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    frame_next = '0;
                    wr_next    = 1'b0;
                    code_next  = '0;
                    if (cur_reg.op == OP_TRANSLATE)
                    begin
                        if (!ent[ENT_PRESENT_BIT])
                        begin
                            status_next = ST_TBL_ABSENT;
                        end
                        else
                        begin
                            status_next = ST_MAPPED_4K;
                            frame_next  = {ent[31:12], 12'd0};
                            wr_next     = ent[ENT_RW_BIT];
                        end
                    end
                    else
                    begin
                        status_next = ST_ERROR_CODE;
                        code_next   = cur_reg.code;
                        code_next[EC_WRITE_BIT] = !ent[ENT_RW_BIT];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_PAGING_OFF;
            frame_reg     <= '0;
            wr_reg        <= 1'b0;
            code_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            frame_reg     <= frame_next;
            wr_reg        <= wr_next;
            code_reg      <= code_next;
        end
    end

    // single port word store, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= q_cmd.data;
        end
        else if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign frame_base   = frame_reg;
    assign writable     = wr_reg;
    assign error_code   = code_reg;

    a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE))
        else $error("store outside idle");

    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || result_ready))
        else $error("result overwritten before taken");

    a_tbl_after_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TBL) |-> ($past(state_reg) == S_DIR || $past(state_reg) == S_TBL))
        else $error("table step without directory step");

    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && q_pop && (q_cmd.op == OP_TRANSLATE || q_cmd.op == OP_FAULT))
        |=> (state_reg == S_DIR))
        else $error("walk did not start");

endmodule

[rtl/x86_two_level_page_walk_unit.sv]
// 32-bit x86 two-level page walk over a word store of guest physical memory.
// items enter on item_valid/item_ready: mode 0 stores a word (byte address, low two
// bits ignored, word index taken modulo MEM_WORDS, which must be a power of two),
// mode 1 translates a virtual address, mode 2 builds a page-fault error code, mode 3
// is accepted and dropped. stores and mode 3 give no result; modes 1 and 2 give one result
// on result_valid/result_ready. a front stage classifies items into a two-entry queue,
// and a back engine drains it against a single-port memory with registered read data.
// a walk reads the directory entry only, or the directory then the table entry: two
// dependent reads of the one memory port, in that order. the memory has no reset
// and no clearing pass; reading a word never written returns whatever it holds.
// paging_enable and dir_base sit on the cfg write port; the user must change them only
// while idle, and the block itself does not enforce this.
module x86_two_level_page_walk_unit #(
    parameter int MEM_WORDS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // input items
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] address,
    input  logic [31:0] data,
    input  logic        access_rejected,
    input  logic        fetch_at_address,
    input  logic        user_mode,
    // result items
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  status,
    output logic [31:0] frame_base,
    output logic        writable,
    output logic [4:0]  error_code
);
    import x86pw_pkg::*;

    logic        paging_enable_reg;
    logic [31:0] dir_base_reg;

    logic    q_full;
    logic    q_push;
    cmd_t    push_cmd;
    logic    q_valid;
    cmd_t    head_cmd;
    logic    q_pop;
    status_t status_w;

    // configuration registers, written on cfg_we, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paging_enable_reg <= 1'b0;
            dir_base_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAGING_ENABLE: paging_enable_reg <= cfg_data[0];
                CFG_DIR_BASE:      dir_base_reg      <= cfg_data;
                default:           paging_enable_reg <= paging_enable_reg;
            endcase
        end
    end

    // front: takes items, decides what the engine must do, drops unused mode
    x86pw_front u_front (
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .mode             (mode),
        .address          (address),
        .data             (data),
        .access_rejected  (access_rejected),
        .fetch_at_address (fetch_at_address),
        .user_mode        (user_mode),
        .paging_enable    (paging_enable_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_cmd            (push_cmd)
    );

    // short queue so the front keeps taking items while a walk runs
    x86pw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .valid    (q_valid),
        .head_cmd (head_cmd),
        .pop      (q_pop)
    );

    // back: memory, walk sequencer and output register
    x86pw_back #(
        .MEM_WORDS (MEM_WORDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .dir_base     (dir_base_reg),
        .q_valid      (q_valid),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status_w),
        .frame_base   (frame_base),
        .writable     (writable),
        .error_code   (error_code)
    );

    assign status = status_w;

endmodule
